/* rtl/sirt_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// sirt_pkg
// Shared types, constants and the digit character lookup for the signed
// integer to radix text converter.
// ============================================================================
package sirt_pkg;

    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int RADIX_W     = 5;
    localparam int CHARS_W     = 64;
    localparam int MAX_RADIX   = 16;
    localparam int MAX_DIGITS  = 32;
    localparam int STACK_AW    = 5;
    localparam int COUNT_W     = 6;
    localparam int BITCNT_W    = 5;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RADIX      = 2'd0,
        REG_CHARS_LOW  = 2'd1,
        REG_CHARS_HIGH = 2'd2
    } cfg_reg_t;

    // Result of the alphabet check: done pulses for one cycle with ok valid.
    typedef struct packed {
        logic done;
        logic ok;
    } chk_status_t;

    // Result of one division: done pulses for one cycle.
    typedef struct packed {
        logic                 done;
        logic [VALUE_W-1:0]   quotient;
        logic [DIGIT_W-1:0]   remainder;
    } div_status_t;

    // Character for digit value d; value 0 sits in the lowest byte of lo.
    function automatic logic [CHAR_W-1:0] glyph(
        input logic [CHARS_W-1:0] lo,
        input logic [CHARS_W-1:0] hi,
        input logic [DIGIT_W-1:0] d
    );
        logic [2*CHARS_W-1:0] all;
        begin
            all = {hi, lo};
            return all[{d, 3'b000} +: CHAR_W];
        end
    endfunction

endpackage

/* rtl/sirt_alpha_check.sv */
`timescale 1ns / 1ps
// ============================================================================
// sirt_alpha_check
// Walks the digit alphabet one entry per cycle and flags a bad alphabet.
// ============================================================================
module sirt_alpha_check (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              go,
    input  logic [sirt_pkg::RADIX_W-1:0]      radix,
    input  logic [sirt_pkg::CHARS_W-1:0]      chars_low,
    input  logic [sirt_pkg::CHARS_W-1:0]      chars_high,
    output sirt_pkg::chk_status_t             status
);

    logic                             running_reg, running_next;
    logic [sirt_pkg::DIGIT_W-1:0]     idx_reg, idx_next;
    logic                             err_reg, err_next;
    logic                             done_reg, done_next;
    logic                             ok_reg, ok_next;
    logic [sirt_pkg::CHAR_W-1:0]      cur_char;
    logic                             bad;
    logic                             at_end;

    // Entry idx is checked against the forbidden characters and against
    // every later entry in use, all in the same cycle.
    always_comb
    begin
        cur_char = sirt_pkg::glyph(chars_low, chars_high, idx_reg);
        bad = (cur_char == sirt_pkg::CHAR_NUL) || (cur_char == sirt_pkg::CHAR_PLUS) ||
              (cur_char == sirt_pkg::CHAR_MINUS);
        for (int b = 0; b < sirt_pkg::MAX_RADIX; b++)
        begin
            if ((sirt_pkg::RADIX_W'(b) > {1'b0, idx_reg}) &&
                (sirt_pkg::RADIX_W'(b) < radix) &&
                (sirt_pkg::glyph(chars_low, chars_high, sirt_pkg::DIGIT_W'(b)) == cur_char))
            begin
                bad = 1'b1;
            end
        end
        at_end = ({1'b0, idx_reg} == (radix - sirt_pkg::RADIX_W'(1)));
    end

    always_comb
    begin
        running_next = running_reg;
        idx_next     = idx_reg;
        err_next     = err_reg;
        done_next    = 1'b0;
        ok_next      = ok_reg;
        if (go)
        begin
            if ((radix < sirt_pkg::RADIX_W'(2)) ||
                (radix > sirt_pkg::RADIX_W'(sirt_pkg::MAX_RADIX)))
            begin
                done_next    = 1'b1;
                ok_next      = 1'b0;
                running_next = 1'b0;
            end
            else
            begin
                running_next = 1'b1;
                idx_next     = '0;
                err_next     = 1'b0;
            end
        end
        else if (running_reg)
        begin
            if (at_end)
            begin
                done_next    = 1'b1;
                ok_next      = !(err_reg || bad);
                running_next = 1'b0;
            end
            else
            begin
                err_next = err_reg || bad;
                idx_next = idx_reg + sirt_pkg::DIGIT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            ok_reg      <= 1'b0;
            err_reg     <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            ok_reg      <= ok_next;
            err_reg     <= err_next;
            idx_reg     <= idx_next;
        end
    end

    assign status.done = done_reg;
    assign status.ok   = ok_reg;

endmodule

/* rtl/sirt_divider.sv */
`timescale 1ns / 1ps
// ============================================================================
// sirt_divider
// Bit-serial restoring divider: a 32-bit dividend by a radix of up to 16.
// ============================================================================
module sirt_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              go,
    input  logic [sirt_pkg::VALUE_W-1:0]      dividend,
    input  logic [sirt_pkg::RADIX_W-1:0]      divisor,
    output sirt_pkg::div_status_t             status
);

    logic                              running_reg, running_next;
    logic                              done_reg, done_next;
    logic [sirt_pkg::BITCNT_W-1:0]     cnt_reg, cnt_next;
    logic [sirt_pkg::VALUE_W-1:0]      q_reg, q_next;
    logic [sirt_pkg::DIGIT_W-1:0]      rem_reg, rem_next;
    logic [sirt_pkg::RADIX_W-1:0]      trial;
    logic                              q_bit;
    logic [sirt_pkg::RADIX_W-1:0]      diff;

    // One dividend bit enters the partial remainder per cycle; the
    // quotient bits shift in behind it in the same register.
    always_comb
    begin
        trial = {rem_reg, q_reg[sirt_pkg::VALUE_W-1]};
        q_bit = (trial >= divisor);
        diff  = trial - divisor;
    end

    always_comb
    begin
        running_next = running_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        q_next       = q_reg;
        rem_next     = rem_reg;
        if (go)
        begin
            running_next = 1'b1;
            cnt_next     = '0;
            q_next       = dividend;
            rem_next     = '0;
        end
        else if (running_reg)
        begin
            q_next   = {q_reg[sirt_pkg::VALUE_W-2:0], q_bit};
            rem_next = q_bit ? diff[sirt_pkg::DIGIT_W-1:0] : trial[sirt_pkg::DIGIT_W-1:0];
            cnt_next = cnt_reg + sirt_pkg::BITCNT_W'(1);
            if (cnt_reg == sirt_pkg::BITCNT_W'(sirt_pkg::VALUE_W - 1))
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            q_reg       <= '0;
            rem_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
            q_reg       <= q_next;
            rem_reg     <= rem_next;
        end
    end

    assign status.done      = done_reg;
    assign status.quotient  = q_reg;
    assign status.remainder = rem_reg;

endmodule

/* rtl/sirt_digit_stack.sv */
`timescale 1ns / 1ps
// ============================================================================
// sirt_digit_stack
// Holds the digits as they are produced so they can be sent out in reverse.
// ============================================================================
module sirt_digit_stack (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [sirt_pkg::STACK_AW-1:0]     wr_addr,
    input  logic [sirt_pkg::DIGIT_W-1:0]      wr_data,
    input  logic [sirt_pkg::STACK_AW-1:0]     rd_addr,
    output logic [sirt_pkg::DIGIT_W-1:0]      rd_data
);

    logic [sirt_pkg::DIGIT_W-1:0] stack_reg [sirt_pkg::MAX_DIGITS];
    logic [sirt_pkg::DIGIT_W-1:0] rd_data_reg;

    // Every entry is written before it is read, so no reset is needed.
    // The read is registered; reading the entry being written returns the
    // new digit, so the top digit is ready the cycle after its push.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_reg[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= stack_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/signed_int_to_custom_radix_text.sv */
`timescale 1ns / 1ps
// ============================================================================
// signed_int_to_custom_radix_text
// Converts a signed 32-bit value to text in a configured radix and digit
// alphabet, one character per result.
// ============================================================================
//
//  Channel   Signals                               Direction  Handshake
//  --------  ------------------------------------  ---------  -------------------
//  request   start, busy, value                    in         start & !busy
//  result    strobe, character, last               out        strobe, one cycle
//  config    cfg_valid, cfg_ready, cfg_index,      in         cfg_valid & cfg_ready
//            cfg_data
//
//  A request first runs the alphabet check, one alphabet entry per cycle.
//  Each digit is then produced by the bit-serial divider, one dividend bit
//  per cycle, and the digit characters are then sent from the stack.
//  Reset clears all control state; the digit stack needs none.
//  Results cannot be stalled; busy stays high until the last one is sent.
//
//  The block first checks the alphabet. A bad alphabet (radix below two or
//  above sixteen, a NUL, '+' or '-' among the digits in use, or a repeated
//  digit character) ends the request with no result. Otherwise a '-' goes
//  out for a negative value, and the magnitude is divided by the radix
//  repeatedly, each remainder pushed on the digit stack, until the quotient
//  is zero. The stack is then popped, most significant digit first, and the
//  final character carries last. A zero value sends the digit-zero
//  character alone. The most negative value converts as magnitude 2^31.
//
module signed_int_to_custom_radix_text (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [sirt_pkg::VALUE_W-1:0]   value,

    output logic                                  strobe,
    output logic [sirt_pkg::CHAR_W-1:0]           character,
    output logic                                  last,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sirt_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [sirt_pkg::CHARS_W-1:0]          cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                             state_reg, state_next;

    // Configuration registers.
    logic [sirt_pkg::RADIX_W-1:0]       radix_reg;
    logic [sirt_pkg::CHARS_W-1:0]       chars_low_reg;
    logic [sirt_pkg::CHARS_W-1:0]       chars_high_reg;

    // Request state.
    logic                               neg_reg, neg_next;
    logic [sirt_pkg::VALUE_W-1:0]       quotient_reg, quotient_next;
    logic [sirt_pkg::COUNT_W-1:0]       count_reg, count_next;

    // Result registers.
    logic                               strobe_reg, strobe_next;
    logic [sirt_pkg::CHAR_W-1:0]        char_reg, char_next;
    logic                               last_reg, last_next;

    logic                               accept;
    logic                               div_go;
    logic [sirt_pkg::VALUE_W-1:0]       div_dividend;
    logic                               push;
    logic [sirt_pkg::COUNT_W-1:0]       pop_ptr;
    logic [sirt_pkg::STACK_AW-1:0]      pop_addr;
    logic [sirt_pkg::DIGIT_W-1:0]       pop_digit;
    logic [sirt_pkg::COUNT_W-1:0]       count_dec;
    sirt_pkg::chk_status_t              chk_stat;
    sirt_pkg::div_status_t              div_stat;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration writes. Writes to an index past the list are dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg      <= '0;
            chars_low_reg  <= '0;
            chars_high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sirt_pkg::REG_RADIX:      radix_reg      <= cfg_data[sirt_pkg::RADIX_W-1:0];
                sirt_pkg::REG_CHARS_LOW:  chars_low_reg  <= cfg_data;
                sirt_pkg::REG_CHARS_HIGH: chars_high_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Units.
    // ------------------------------------------------------------------
    sirt_alpha_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (accept),
        .radix      (radix_reg),
        .chars_low  (chars_low_reg),
        .chars_high (chars_high_reg),
        .status     (chk_stat)
    );

    sirt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_dividend),
        .divisor  (radix_reg),
        .status   (div_stat)
    );

    // The first division takes the magnitude; later ones take the quotient
    // that the divider just produced.
    assign div_dividend = (state_reg == ST_CHECK) ? quotient_reg : div_stat.quotient;
    assign count_dec    = count_reg - sirt_pkg::COUNT_W'(1);

    // The stack read is registered, so the address is the top of the stack
    // as it will stand in the next cycle.
    assign pop_ptr      = count_next - sirt_pkg::COUNT_W'(1);
    assign pop_addr     = pop_ptr[sirt_pkg::STACK_AW-1:0];

    sirt_digit_stack u_stack (
        .clk     (clk),
        .wr_en   (push),
        .wr_addr (count_reg[sirt_pkg::STACK_AW-1:0]),
        .wr_data (div_stat.remainder),
        .rd_addr (pop_addr),
        .rd_data (pop_digit)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        neg_next      = neg_reg;
        quotient_next = quotient_reg;
        count_next    = count_reg;
        strobe_next   = 1'b0;
        char_next     = char_reg;
        last_next     = last_reg;
        div_go        = 1'b0;
        push          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next      = value[sirt_pkg::VALUE_W-1];
                    quotient_next = value[sirt_pkg::VALUE_W-1] ?
                                    (sirt_pkg::VALUE_W'(0) - sirt_pkg::VALUE_W'(value)) :
                                    sirt_pkg::VALUE_W'(value);
                    count_next    = '0;
                    state_next    = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (chk_stat.done)
                begin
                    if (!chk_stat.ok)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (quotient_reg == '0)
                    begin
                        // Zero is never negative, so this is the only result.
                        strobe_next = 1'b1;
                        char_next   = sirt_pkg::glyph(chars_low_reg, chars_high_reg, '0);
                        last_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        if (neg_reg)
                        begin
                            strobe_next = 1'b1;
                            char_next   = sirt_pkg::CHAR_MINUS;
                            last_next   = 1'b0;
                        end
                        div_go     = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    push          = 1'b1;
                    count_next    = count_reg + sirt_pkg::COUNT_W'(1);
                    quotient_next = div_stat.quotient;
                    if (div_stat.quotient == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        div_go = 1'b1;
                    end
                end
            end

            ST_EMIT:
            begin
                // Pop one digit per cycle, most significant first.
                strobe_next = 1'b1;
                char_next   = sirt_pkg::glyph(chars_low_reg, chars_high_reg, pop_digit);
                last_next   = (count_reg == sirt_pkg::COUNT_W'(1));
                count_next  = count_dec;
                if (count_reg == sirt_pkg::COUNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            neg_reg      <= 1'b0;
            quotient_reg <= '0;
            count_reg    <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            neg_reg      <= neg_next;
            quotient_reg <= quotient_next;
            count_reg    <= count_next;
            strobe_reg   <= strobe_next;
        end
    end

    // Result payload needs no reset; it is only looked at under strobe.
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule
